/* rtl/fedc_pkg.sv */
// ----------------------------------------------------------------------------
// fedc_pkg: shared types, constants and rate helpers
// Word formats, sequencer states and the envelope rate, wait and increment
// lookups used by the FM envelope duration calculator.
// ----------------------------------------------------------------------------
package fedc_pkg;

	localparam int LVL_W  = 10;  // envelope level, 0..1023
	localparam int RATE_W = 6;   // effective rate, 0..63
	localparam int WAIT_W = 12;  // wait between updates, up to 2048
	localparam int ACC_W  = 24;  // raw cycle accumulators
	localparam int CYC_W  = 22;  // attack / decay count fields
	localparam int TOT_W  = 23;  // total count field

	localparam logic [LVL_W-1:0]  SSG_TOP     = 10'd511;
	localparam logic [LVL_W-1:0]  LEVEL_CEIL  = 10'd1023;
	localparam logic [6:0]        RATE_TOP    = 7'd63;
	localparam logic [RATE_W-1:0] RATE_FAST   = 6'd62;
	localparam logic [3:0]        SL_MAX_CODE = 4'd15;

	typedef struct packed {
		logic [4:0] attack_rate;
		logic [4:0] decay_rate;
		logic [3:0] sustain_level;
		logic [4:0] second_decay_rate;
		logic [1:0] key_scale;
	} fedc_item_t;

	typedef struct packed {
		logic [CYC_W-1:0] attack_cycles;
		logic [CYC_W-1:0] decay_cycles;
		logic [TOT_W-1:0] total_cycles;
		logic             status;
	} fedc_result_t;

	// raw figures from the sequencer, before capping
	typedef struct packed {
		logic [ACC_W-1:0] att_acc;
		logic [ACC_W-1:0] dec_acc;
		logic             att_endless;
		logic             dec_endless;
	} fedc_raw_t;

	// operands for the shared level unit
	typedef struct packed {
		logic              attack;
		logic [RATE_W-1:0] rate;
		logic [2:0]        idx;
		logic [LVL_W-1:0]  level;
		logic [LVL_W-1:0]  target;
	} fedc_step_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ATT_INIT,
		ST_ATT,
		ST_DEC_INIT,
		ST_D1,
		ST_D2_INIT,
		ST_D2,
		ST_DONE
	} fedc_state_t;

	// rows 0..3: patterns below rate 48; rows 4..7: multipliers for 48..59
	localparam logic [1:0] INC_PAT [8][8] = '{
		'{2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1},
		'{2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1},
		'{2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1},
		'{2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
		'{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
		'{2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2},
		'{2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2},
		'{2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2}
	};

	function automatic logic [RATE_W-1:0] calc_rate(input logic [4:0] r,
		input logic [1:0] ks);
		logic [6:0] v;
		v = {1'b0, r, 1'b0} + {5'b0, ks};
		if (r == 5'd0) begin
			return '0;
		end
		return (v > RATE_TOP) ? RATE_TOP[RATE_W-1:0] : v[RATE_W-1:0];
	endfunction

	function automatic logic [WAIT_W-1:0] wait_of(input logic [RATE_W-1:0] rate);
		logic [3:0] sh;
		sh = (rate < 6'd44) ? (4'd11 - rate[5:2]) : 4'd0;
		return WAIT_W'(1) << sh;
	endfunction

	function automatic logic [3:0] inc_of(input logic [RATE_W-1:0] rate,
		input logic [2:0] idx);
		logic [1:0]        p;
		logic [RATE_W-1:0] off;
		logic [3:0]        r;
		p   = INC_PAT[{1'b1, rate[1:0]}][idx];
		off = rate - 6'd48;
		if (rate < 6'd2) begin
			r = 4'd0;
		end else if (rate < 6'd6) begin
			r = {2'b0, INC_PAT[3'd0][idx]};
		end else if (rate < 6'd8) begin
			r = {2'b0, INC_PAT[3'd2][idx]};
		end else if (rate < 6'd48) begin
			r = {2'b0, INC_PAT[{1'b0, rate[1:0]}][idx]};
		end else if (rate < 6'd60) begin
			r = {2'b0, p} << off[3:2];
		end else begin
			r = 4'd8;
		end
		return r;
	endfunction

	// first decay end point: 32 * code, top code means 511, never past 511
	function automatic logic [LVL_W-1:0] sustain_target(input logic [3:0] sl);
		return (sl == SL_MAX_CODE) ? SSG_TOP : {1'b0, sl, 5'b0};
	endfunction

endpackage

/* rtl/fedc_step_unit.sv */
// ----------------------------------------------------------------------------
// fedc_step_unit: shared envelope level update
// One update event: attack falls by ceil(inc*(v+1)/16), decay rises by 4*inc,
// plus the end-of-phase compare.
// ----------------------------------------------------------------------------
module fedc_step_unit (
	input  fedc_pkg::fedc_step_op_t        op,
	output logic [fedc_pkg::LVL_W-1:0]     level_nxt,
	output logic                           reached
);
	import fedc_pkg::*;

	logic [3:0]       inc;
	logic [13:0]      prod;
	logic [13:0]      prod_rnd;
	logic [LVL_W-1:0] att_d;
	logic [LVL_W-1:0] att_lvl;
	logic [LVL_W-1:0] dec_step;
	logic [LVL_W-1:0] room;
	logic [LVL_W-1:0] dec_lvl;

	always_comb begin
		inc      = inc_of(op.rate, op.idx);
		// inc <= 8 and v+1 <= 1024, product fits 14 bits
		prod     = 14'(inc) * (14'(op.level) + 14'd1);
		prod_rnd = prod + 14'd15;
		att_d    = prod_rnd[13:4];
		att_lvl  = (att_d < op.level) ? (op.level - att_d) : '0;

		dec_step = {4'b0, inc, 2'b00};
		room     = LEVEL_CEIL - op.level;
		dec_lvl  = op.level + ((dec_step < room) ? dec_step : room);

		level_nxt = op.attack ? att_lvl : dec_lvl;
		reached   = op.attack ? (att_lvl == '0) : (dec_lvl >= op.target);
	end

endmodule

/* rtl/fedc_seq.sv */
// ----------------------------------------------------------------------------
// fedc_seq: phase sequencer
// Walks attack, first decay and second decay one update event per cycle
// through the shared level unit and sums the waits between updates.
// ----------------------------------------------------------------------------
module fedc_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  fedc_pkg::fedc_item_t   item,
	input  logic                   out_free,
	output logic                   busy,
	output logic                   done,
	output fedc_pkg::fedc_raw_t    raw
);
	import fedc_pkg::*;

	fedc_state_t       state_q;
	fedc_state_t       state_nxt;
	fedc_item_t        item_q;
	logic [LVL_W-1:0]  v_q;
	logic [LVL_W-1:0]  target_q;
	logic [RATE_W-1:0] rate_q;
	logic [2:0]        idx_q;
	logic [ACC_W-1:0]  att_acc_q;
	logic [ACC_W-1:0]  dec_acc_q;
	logic              att_end_q;
	logic              dec_end_q;
	logic              n1_nz_q;
	logic              first_q;

	logic [RATE_W-1:0] ar_rate;
	logic [RATE_W-1:0] dr_rate;
	logic [RATE_W-1:0] d2_rate;
	logic [LVL_W-1:0]  tgt;
	logic [WAIT_W-1:0] w_cur;
	logic [WAIT_W-1:0] w2;
	logic [WAIT_W-1:0] carry_cnt;
	fedc_step_op_t     op;
	logic [LVL_W-1:0]  level_nxt;
	logic              reached;

	fedc_step_unit u_step (
		.op        (op),
		.level_nxt (level_nxt),
		.reached   (reached)
	);

	always_comb begin
		ar_rate   = calc_rate(item_q.attack_rate, item_q.key_scale);
		dr_rate   = calc_rate(item_q.decay_rate, item_q.key_scale);
		d2_rate   = calc_rate(item_q.second_decay_rate, item_q.key_scale);
		tgt       = sustain_target(item_q.sustain_level);
		w_cur     = wait_of(rate_q);
		w2        = wait_of(d2_rate);
		// leftover wait counter of the first decay, wrapped to the new wait
		carry_cnt = (n1_nz_q ? (w_cur - WAIT_W'(1)) : w_cur) & (w2 - WAIT_W'(1));
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_ATT_INIT;
			end
			ST_ATT_INIT: begin
				if (ar_rate >= RATE_FAST || ar_rate == '0) state_nxt = ST_DEC_INIT;
				else state_nxt = ST_ATT;
			end
			ST_ATT: begin
				if (reached) state_nxt = ST_DEC_INIT;
			end
			ST_DEC_INIT: begin
				if (tgt != '0 && dr_rate == '0) state_nxt = ST_DONE;
				else if (tgt == '0) state_nxt = ST_D2_INIT;
				else state_nxt = ST_D1;
			end
			ST_D1: begin
				if (reached) state_nxt = ST_D2_INIT;
			end
			ST_D2_INIT: begin
				if (v_q >= SSG_TOP || d2_rate == '0) state_nxt = ST_DONE;
				else state_nxt = ST_D2;
			end
			ST_D2: begin
				if (reached) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy            = (state_q != ST_IDLE);
		done            = (state_q == ST_DONE);
		op.attack       = (state_q == ST_ATT);
		op.rate         = rate_q;
		op.idx          = idx_q;
		op.level        = v_q;
		op.target       = target_q;
		raw.att_acc     = att_acc_q;
		raw.dec_acc     = dec_acc_q;
		raw.att_endless = att_end_q;
		raw.dec_endless = dec_end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) item_q <= item;
			end
			ST_ATT_INIT: begin
				rate_q    <= ar_rate;
				v_q       <= SSG_TOP;
				idx_q     <= '0;
				att_end_q <= (ar_rate == '0);
				att_acc_q <= (ar_rate >= RATE_FAST) ? ACC_W'(1) : '0;
			end
			ST_ATT: begin
				v_q       <= level_nxt;
				idx_q     <= idx_q + 3'd1;
				att_acc_q <= att_acc_q + ACC_W'(w_cur);
			end
			ST_DEC_INIT: begin
				rate_q    <= dr_rate;
				target_q  <= tgt;
				v_q       <= '0;
				idx_q     <= '0;
				dec_acc_q <= '0;
				n1_nz_q   <= 1'b0;
				dec_end_q <= (tgt != '0 && dr_rate == '0);
			end
			ST_D1: begin
				v_q       <= level_nxt;
				idx_q     <= idx_q + 3'd1;
				dec_acc_q <= dec_acc_q + ACC_W'(w_cur);
				n1_nz_q   <= 1'b1;
			end
			ST_D2_INIT: begin
				rate_q   <= d2_rate;
				target_q <= SSG_TOP;
				first_q  <= 1'b1;
				if (v_q < SSG_TOP) begin
					if (d2_rate == '0) begin
						dec_end_q <= 1'b1;
					end else begin
						dec_acc_q <= dec_acc_q + ACC_W'(n1_nz_q) + ACC_W'(carry_cnt);
					end
				end
			end
			ST_D2: begin
				// first update of the second decay lands after the carried count
				v_q       <= level_nxt;
				idx_q     <= idx_q + 3'd1;
				first_q   <= 1'b0;
				dec_acc_q <= dec_acc_q + (first_q ? '0 : ACC_W'(w_cur));
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/fm_envelope_duration_calc_core.sv */
// ----------------------------------------------------------------------------
// fm_envelope_duration_calc_core: FM envelope phase timing calculator
// Counts the envelope cycles of the attack phase and the two decay phases of
// one SSG-EG style envelope setting.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   (item_valid / item_stall / item): one envelope setting per
//                  word. item_stall is high while a setting is being worked on.
//   result channel (result_valid / result_stall / result): one word per
//                  setting with attack, decay and total counts and status.
// Phases: the shared level unit does one envelope update event per cycle,
//   with setup states before the phases and a done state after them; waits
//   between updates are added in one step, not ticked out.
// Throughput: one setting at a time; a new word is taken as soon as the
//   sequencer is back in idle, even if the last result is still held.
// Stall: a finished result waits in the output register; if that register
//   is still full the sequencer holds in its done state until it drains.
// Reset: arst_n clears the sequencer and the output valid; no clearing pass.
// COUNT_BITS sets the saturation point of the attack and decay counts
//   (2^COUNT_BITS - 1, and never past the 22-bit field).
// ----------------------------------------------------------------------------
module fm_envelope_duration_calc_core #(
	parameter int COUNT_BITS = 22
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  fedc_pkg::fedc_item_t    item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output fedc_pkg::fedc_result_t  result
);
	import fedc_pkg::*;

	// saturation point of a phase count
	localparam logic [63:0]      CAP_FULL = (64'd1 << COUNT_BITS) - 64'd1;
	localparam logic [CYC_W-1:0] CNT_CAP  =
		(COUNT_BITS >= CYC_W) ? '1 : CAP_FULL[CYC_W-1:0];

	logic         start;
	logic         busy;
	logic         done;
	logic         out_free;
	fedc_raw_t    raw;

	logic [CYC_W-1:0] att_cyc;
	logic [CYC_W-1:0] dec_cyc;
	fedc_result_t     res_nxt;

	logic         result_valid_q;
	fedc_result_t result_q;

	// an item is taken only with the sequencer idle
	assign item_stall = busy;
	assign start      = item_valid && !item_stall;
	// output register is free when empty or draining this cycle
	assign out_free   = !result_valid_q || !result_stall;

	fedc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.out_free (out_free),
		.busy     (busy),
		.done     (done),
		.raw      (raw)
	);

	// cap each phase; an endless phase reports the cap
	always_comb begin
		att_cyc = (raw.att_endless || raw.att_acc > ACC_W'(CNT_CAP)) ?
			CNT_CAP : raw.att_acc[CYC_W-1:0];
		dec_cyc = (raw.dec_endless || raw.dec_acc > ACC_W'(CNT_CAP)) ?
			CNT_CAP : raw.dec_acc[CYC_W-1:0];
		res_nxt.attack_cycles = att_cyc;
		res_nxt.decay_cycles  = dec_cyc;
		// two capped 22-bit counts never reach the 23-bit field limit
		res_nxt.total_cycles  = {1'b0, att_cyc} + {1'b0, dec_cyc};
		res_nxt.status        = raw.att_endless || raw.dec_endless;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (done && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/fedc_checker.sv */
// ----------------------------------------------------------------------------
// fedc_checker: port-level checks for the envelope duration calculator
// Watches the item and result channels of the top level only.
// ----------------------------------------------------------------------------
module fedc_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_valid,
	input logic                    item_stall,
	input fedc_pkg::fedc_item_t    item,
	input logic                    result_valid,
	input logic                    result_stall,
	input fedc_pkg::fedc_result_t  result
);
	import fedc_pkg::*;

	// one setting at a time: busy right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while previous setting still in work");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed or dropped");

	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.total_cycles ==
			({1'b0, result.attack_cycles} + {1'b0, result.decay_cycles}))
		else $error("total count is not attack plus decay");

	// attack count is never zero, also when saturated
	a_attack_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.attack_cycles != '0)
		else $error("attack count of zero");

endmodule

bind fm_envelope_duration_calc_core fedc_checker u_fedc_checker (.*);
